// ===== src/ctad_pkg.sv =====
// Shared types and constants for the crank trigger angle and speed decoder.
// Used by the configuration interface, the register bank, the core and the top level.
`timescale 1ns / 1ps

package ctad_pkg;

  localparam int CFG_ANGLE_W = 13;
  localparam int CFG_TIMER_W = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PULSE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SYNC  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CYCLE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TMAX  = CFG_IDX_W'(3);

  localparam logic [CFG_ANGLE_W-1:0] PULSE_ANGLE_RST = CFG_ANGLE_W'(300);
  localparam logic [CFG_ANGLE_W-1:0] SYNC_ANGLE_RST  = CFG_ANGLE_W'(0);
  localparam logic [CFG_ANGLE_W-1:0] CYCLE_ANGLE_RST = CFG_ANGLE_W'(7200);
  localparam logic [CFG_TIMER_W-1:0] TIMER_MAX_RST   = CFG_TIMER_W'(65535);

  typedef enum logic [1:0] {
    REQ_SYNC     = 2'd0,
    REQ_CAPTURE  = 2'd1,
    REQ_OVERFLOW = 2'd2
  } req_t;

  typedef struct packed {
    logic [CFG_ANGLE_W-1:0] pulse_angle;
    logic [CFG_ANGLE_W-1:0] sync_angle;
    logic [CFG_ANGLE_W-1:0] cycle_angle;
    logic [CFG_TIMER_W-1:0] timer_max;
  } cfg_t;

  typedef struct packed {
    logic cause;
    logic trigger_fire;
    logic angle_valid;
    logic period_valid;
  } res_flags_t;

endpackage

// ===== src/ctad_in_if.sv =====
// Input event channel: valid/ready handshake with request kind and capture value.
// Standalone, no package dependency.
`timescale 1ns / 1ps

interface ctad_in_if #(
  parameter int TIMER_WIDTH = 16
) ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             req_type;
  logic [TIMER_WIDTH-1:0] capture_value;

  modport source (output valid, req_type, capture_value, input ready);
  modport sink   (input valid, req_type, capture_value, output ready);
endinterface

// ===== src/ctad_out_if.sv =====
// Result channel: valid/ready handshake with angle and tooth period payload.
// Standalone, no package dependency.
`timescale 1ns / 1ps

interface ctad_out_if #(
  parameter int TIMER_WIDTH = 16,
  parameter int ANGLE_WIDTH = 13
) ();
  logic                   valid;
  logic                   ready;
  logic                   cause;
  logic                   trigger_fire;
  logic [ANGLE_WIDTH-1:0] angle;
  logic                   angle_valid;
  logic [TIMER_WIDTH-1:0] period;
  logic                   period_valid;

  modport source (output valid, cause, trigger_fire, angle, angle_valid, period,
                  period_valid, input ready);
  modport sink   (input valid, cause, trigger_fire, angle, angle_valid, period,
                  period_valid, output ready);
endinterface

// ===== src/ctad_cfg_if.sv =====
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on ctad_pkg for the index and data widths.
`timescale 1ns / 1ps

interface ctad_cfg_if import ctad_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/ctad_cfg.sv =====
// Configuration register bank: takes write beats and holds the four settings.
// Depends on ctad_pkg and ctad_cfg_if.
`timescale 1ns / 1ps

module ctad_cfg import ctad_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ctad_cfg_if.sink    cfg_ch,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_IDX_PULSE: cfg_nxt.pulse_angle = cfg_ch.data[CFG_ANGLE_W-1:0];
        CFG_IDX_SYNC:  cfg_nxt.sync_angle  = cfg_ch.data[CFG_ANGLE_W-1:0];
        CFG_IDX_CYCLE: cfg_nxt.cycle_angle = cfg_ch.data[CFG_ANGLE_W-1:0];
        CFG_IDX_TMAX:  cfg_nxt.timer_max   = cfg_ch.data[CFG_TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_angle <= PULSE_ANGLE_RST;
      cfg_r.sync_angle  <= SYNC_ANGLE_RST;
      cfg_r.cycle_angle <= CYCLE_ANGLE_RST;
      cfg_r.timer_max   <= TIMER_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/ctad_core.sv =====
// Decoder state and per-event logic: sync flag, angle tracking, period measurement
// and loss-of-signal detection. Depends on ctad_pkg.
`timescale 1ns / 1ps

module ctad_core import ctad_pkg::*; #(
  parameter int TIMER_WIDTH = 16,
  parameter int ANGLE_WIDTH = 13
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [1:0]             req_type,
  input  logic [TIMER_WIDTH-1:0] capture,
  input  cfg_t                   cfg,
  output logic                   res_valid,
  output res_flags_t             res_flags,
  output logic [ANGLE_WIDTH-1:0] res_angle,
  output logic [TIMER_WIDTH-1:0] res_period
);

  localparam int SUM_W = ((ANGLE_WIDTH > CFG_ANGLE_W) ? ANGLE_WIDTH : CFG_ANGLE_W) + 1;

  logic                   sync_pending_r, sync_pending_nxt;
  logic [ANGLE_WIDTH-1:0] angle_r, angle_nxt;
  logic                   angle_known_r, angle_known_nxt;
  logic [TIMER_WIDTH-1:0] last_cap_r, last_cap_nxt;
  logic                   last_cap_vld_r, last_cap_vld_nxt;
  logic                   ovf_seen_r, ovf_seen_nxt;

  logic [SUM_W-1:0]       angle_sum;
  logic [SUM_W-1:0]       angle_wrap;
  logic [ANGLE_WIDTH-1:0] angle_adv;
  logic [TIMER_WIDTH-1:0] tmax_ext;
  logic [TIMER_WIDTH-1:0] period_raw;

  assign angle_sum  = SUM_W'(angle_r) + SUM_W'(cfg.pulse_angle);
  assign angle_wrap = (angle_sum >= SUM_W'(cfg.cycle_angle)) ?
                      angle_sum - SUM_W'(cfg.cycle_angle) : angle_sum;
  assign angle_adv  = ANGLE_WIDTH'(angle_wrap);

  assign tmax_ext   = TIMER_WIDTH'(cfg.timer_max);
  assign period_raw = (capture >= last_cap_r) ? capture - last_cap_r
                                              : tmax_ext + TIMER_WIDTH'(1) - last_cap_r + capture;

  always_comb begin
    sync_pending_nxt = sync_pending_r;
    angle_nxt        = angle_r;
    angle_known_nxt  = angle_known_r;
    last_cap_nxt     = last_cap_r;
    last_cap_vld_nxt = last_cap_vld_r;
    ovf_seen_nxt     = ovf_seen_r;
    res_valid        = 1'b0;
    res_flags        = '0;
    res_angle        = '0;
    res_period       = '0;
    if (step) begin
      unique case (req_type)
        REQ_SYNC: begin
          sync_pending_nxt = 1'b1;
        end
        REQ_CAPTURE: begin
          if (sync_pending_r) begin
            angle_nxt        = ANGLE_WIDTH'(cfg.sync_angle);
            angle_known_nxt  = 1'b1;
            sync_pending_nxt = 1'b0;
          end else if (angle_known_r) begin
            angle_nxt = angle_adv;
          end
          last_cap_nxt           = capture;
          last_cap_vld_nxt       = 1'b1;
          ovf_seen_nxt           = 1'b0;
          res_valid              = 1'b1;
          res_flags.trigger_fire = 1'b1;
          res_flags.angle_valid  = angle_known_nxt;
          res_flags.period_valid = last_cap_vld_r;
          res_angle              = angle_known_nxt ? angle_nxt : '0;
          res_period             = last_cap_vld_r ? period_raw : '0;
        end
        REQ_OVERFLOW: begin
          if (ovf_seen_r) begin
            last_cap_vld_nxt = 1'b0;
            angle_known_nxt  = 1'b0;
            angle_nxt        = '0;
            res_valid        = 1'b1;
            res_flags.cause  = 1'b1;
          end
          ovf_seen_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_pending_r <= 1'b0;
      angle_r        <= '0;
      angle_known_r  <= 1'b0;
      last_cap_r     <= '0;
      last_cap_vld_r <= 1'b0;
      ovf_seen_r     <= 1'b0;
    end else begin
      sync_pending_r <= sync_pending_nxt;
      angle_r        <= angle_nxt;
      angle_known_r  <= angle_known_nxt;
      last_cap_r     <= last_cap_nxt;
      last_cap_vld_r <= last_cap_vld_nxt;
      ovf_seen_r     <= ovf_seen_nxt;
    end
  end

endmodule

// ===== src/crank_trigger_angle_speed_decoder.sv =====
// Crank trigger angle and speed decoder, top level.
// Depends on ctad_pkg, the three channel interfaces, ctad_cfg and ctad_core.
//
// Usage:
//   in_ch   event beats: sync edge, tooth capture (with timer value) or timer overflow.
//   out_ch  result beats: tooth update (angle, period) or loss-of-signal timeout.
//   cfg_ch  register writes, index 0 to 3: pulse, sync and cycle angle, timer max.
//           Always ready; write only while no event is in flight.
// Timing:
//   An accepted beat lands in the input register and is decoded while it sits there;
//   its result, if any, is loaded into the output register once that register can
//   advance. One beat per cycle is sustained while out_ch.ready is high; the state
//   update of one event and the output load happen in the same cycle, so back-to-back
//   events chain. Sync edges, first overflows and unused request codes give no result.
// Stall:
//   While the output register holds an untaken result, the input register holds its
//   beat; in_ch.ready stays high as long as the input register is empty.
// Reset:
//   rst_n clears both pipeline stages, the decoder state (angle unknown, no previous
//   capture, no pending sync) and loads the register defaults.
`timescale 1ns / 1ps

module crank_trigger_angle_speed_decoder import ctad_pkg::*; #(
  parameter int TIMER_WIDTH = 16,
  parameter int ANGLE_WIDTH = 13
) (
  input  logic       clk,
  input  logic       rst_n,
  ctad_in_if.sink    in_ch,
  ctad_out_if.source out_ch,
  ctad_cfg_if.sink   cfg_ch
);

  cfg_t                   cfg;
  logic                   in_vld_r;
  logic [1:0]             in_req_r;
  logic [TIMER_WIDTH-1:0] in_cap_r;
  logic                   advance;
  logic                   step;

  logic                   res_valid;
  res_flags_t             res_flags;
  logic [ANGLE_WIDTH-1:0] res_angle;
  logic [TIMER_WIDTH-1:0] res_period;

  logic                   out_vld_r;
  res_flags_t             out_flags_r;
  logic [ANGLE_WIDTH-1:0] out_angle_r;
  logic [TIMER_WIDTH-1:0] out_period_r;

  assign advance     = !out_vld_r || out_ch.ready;
  assign step        = in_vld_r && advance;
  assign in_ch.ready = !in_vld_r || advance;

  ctad_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  ctad_core #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .req_type   (in_req_r),
    .capture    (in_cap_r),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res_flags  (res_flags),
    .res_angle  (res_angle),
    .res_period (res_period)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_req_r <= in_ch.req_type;
      in_cap_r <= in_ch.capture_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_flags_r  <= res_flags;
      out_angle_r  <= res_angle;
      out_period_r <= res_period;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.cause        = out_flags_r.cause;
  assign out_ch.trigger_fire = out_flags_r.trigger_fire;
  assign out_ch.angle        = out_angle_r;
  assign out_ch.angle_valid  = out_flags_r.angle_valid;
  assign out_ch.period       = out_period_r;
  assign out_ch.period_valid = out_flags_r.period_valid;

`ifndef SYNTHESIS
  a_capture_yields_beat: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_req_r == REQ_CAPTURE |=> out_vld_r)
    else $error("capture event produced no result beat");

  a_stalled_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r)
    else $error("pending input beat dropped while stalled");

  a_timeout_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_flags_r.cause |->
      !out_flags_r.trigger_fire && !out_flags_r.angle_valid && !out_flags_r.period_valid)
    else $error("timeout beat carries tooth data");

  a_update_fires: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_flags_r.cause |-> out_flags_r.trigger_fire)
    else $error("tooth update beat without trigger fire");
`endif

endmodule
